@@ design/top_k_fitness_selector_assert.svh @@
// assertion macros shared by the top k fitness selector
`ifndef TOP_K_FITNESS_SELECTOR_ASSERT_SVH
`define TOP_K_FITNESS_SELECTOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define TKFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define TKFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/tkfs_pkg.sv @@
// types and constants of the top k fitness selector
package tkfs_pkg;

  localparam int TOP_PLACES = 8;
  localparam int COUNT_W    = 4;
  localparam int RANK_W     = 3;
  localparam int CNT_W      = $clog2(TOP_PLACES + 1);
  localparam int IDX_W      = (TOP_PLACES > 1) ? $clog2(TOP_PLACES) : 1;
  localparam int SEL_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef struct packed {
    logic [15:0]        cand_id;
    logic signed [31:0] cand_fitness;
    logic               gen_last;
  } tkfs_in_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [15:0]        best_id;
    logic signed [31:0] best_fitness;
    logic               slot_filled;
    logic               last_place;
  } tkfs_out_t;

  typedef struct packed {
    logic               valid;
    logic [15:0]        id;
    logic signed [31:0] fitness;
  } tkfs_place_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } tkfs_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_READOUT
  } tkfs_state_e;

endpackage

@@ design/tkfs_cell.sv @@
// one place of the ranking chain: compare, insert, shift down, pop up
module tkfs_cell
  import tkfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tkfs_ctrl_t  ctrl_i,
  input  logic        active_i,
  input  tkfs_place_t cand_i,
  input  logic        taken_i,
  input  tkfs_place_t prev_i,
  input  tkfs_place_t next_i,
  output logic        taken_o,
  output tkfs_place_t place_o
);

  logic               valid_q, valid_d;
  logic [15:0]        id_q, id_d;
  logic signed [31:0] fit_q, fit_d;
  logic               take, shift, beats;

  assign beats   = $signed(cand_i.fitness) > $signed(fit_q);
  assign take    = ctrl_i.ins && active_i && !taken_i && (!valid_q || beats);
  assign shift   = ctrl_i.ins && active_i && taken_i && prev_i.valid;
  assign taken_o = taken_i || take;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    fit_d   = fit_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = next_i.valid;
      id_d    = next_i.id;
      fit_d   = next_i.fitness;
    end else if (take) begin
      valid_d = 1'b1;
      id_d    = cand_i.id;
      fit_d   = cand_i.fitness;
    end else if (shift) begin
      valid_d = 1'b1;
      id_d    = prev_i.id;
      fit_d   = prev_i.fitness;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    fit_q <= fit_d;
  end

  assign place_o = '{valid: valid_q, id: id_q, fitness: fit_q};

endmodule

@@ design/top_k_fitness_selector.sv @@
// top level of the top k fitness selector: cell chain, readout and config
//
// usage
//   input channel (in_valid_i, in_stall_o, in_data_i): one scored candidate per
//   item; an item is taken at an edge with in_valid_i high and in_stall_o low
//   output channel (out_valid_o, out_stall_i, out_data_o): ranked places, best
//   first, one result item per edge with out_valid_o high and out_stall_i low
//   config channel (cfg_valid_i, cfg_ready_o, cfg_data_i): active_count, the
//   number of places kept and reported; 0 acts as 1, large values saturate
// timing
//   a candidate is compared against every cell at once and inserted in the
//   edge that takes it, so one candidate per cycle is sustained while collecting
//   an item with gen_last set starts the readout: the state register moves to
//   readout, then the output register shows the first result, then one result
//   per cycle while out_stall_i is low, n results in all; the chain shifts up
//   by one place per result; in_stall_o is high for the whole readout
//   out_stall_i holds the output register and the chain, nothing is lost
// reset
//   all places empty, active_count back to 8, no result pending
`include "top_k_fitness_selector_assert.svh"

module top_k_fitness_selector
  import tkfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tkfs_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tkfs_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i
);

  // configuration register
  logic [COUNT_W-1:0] active_count_q;

  // readout sequencer
  tkfs_state_e        state_q, state_d;
  logic [IDX_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               out_valid_q, out_valid_d;
  tkfs_out_t          out_data_q, out_data_d;

  // chain
  tkfs_ctrl_t         ctrl;
  tkfs_place_t        cand;
  tkfs_place_t        cell_place [TOP_PLACES];
  logic [TOP_PLACES:0] taken;
  logic [TOP_PLACES-1:0] cell_valid;

  logic               in_accept;
  logic               pop;
  logic               last_pop;
  logic [SEL_W-1:0]   cfg_ext;
  logic [SEL_W-1:0]   n_ext;
  logic [CNT_W-1:0]   places_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= COUNT_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_count_q <= cfg_data_i;
    end
  end

  // places in use: zero acts as one, above the chain length saturates
  assign cfg_ext = SEL_W'(active_count_q);
  always_comb begin
    if (cfg_ext == '0) begin
      n_ext = SEL_W'(1);
    end else if (cfg_ext > SEL_W'(TOP_PLACES)) begin
      n_ext = SEL_W'(TOP_PLACES);
    end else begin
      n_ext = cfg_ext;
    end
  end
  assign places_n = CNT_W'(n_ext);

  // candidates are only taken while collecting
  assign in_stall_o = (state_q == ST_READOUT);
  assign in_accept  = in_valid_i && !in_stall_o;

  // a place pops when the output register is free or being drained
  assign pop      = (state_q == ST_READOUT) && (!out_valid_q || !out_stall_i);
  assign last_pop = pop && ((CNT_W'(rd_cnt_q) + CNT_W'(1)) == places_n);

  assign ctrl.ins = in_accept;
  assign ctrl.pop = pop;
  assign ctrl.clr = last_pop;  // readout end empties every place, beyond n too

  assign cand = '{valid: 1'b1, id: in_data_i.cand_id, fitness: in_data_i.cand_fitness};

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < TOP_PLACES; i++) begin : g_cell
    tkfs_place_t prev_place;
    tkfs_place_t next_place;

    if (i == 0) begin : g_head
      assign prev_place = '0;
    end else begin : g_body
      assign prev_place = cell_place[i-1];
    end

    if (i == TOP_PLACES - 1) begin : g_tail
      assign next_place = '0;
    end else begin : g_link
      assign next_place = cell_place[i+1];
    end

    tkfs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (CNT_W'(i) < places_n),
      .cand_i   (cand),
      .taken_i  (taken[i]),
      .prev_i   (prev_place),
      .next_i   (next_place),
      .taken_o  (taken[i+1]),
      .place_o  (cell_place[i])
    );

    assign cell_valid[i] = cell_place[i].valid;
  end

  // readout sequencer: next state and output register
  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_COLLECT: begin
        if (in_accept && in_data_i.gen_last) begin
          state_d  = ST_READOUT;
          rd_cnt_d = '0;
        end
      end
      ST_READOUT: begin
        if (pop) begin
          out_valid_d             = 1'b1;
          out_data_d.rank         = RANK_W'(rd_cnt_q);
          out_data_d.slot_filled  = cell_place[0].valid;
          out_data_d.best_id      = cell_place[0].valid ? cell_place[0].id : '0;
          out_data_d.best_fitness = cell_place[0].valid ? cell_place[0].fitness : '0;
          out_data_d.last_place   = last_pop;
          if (last_pop) begin
            state_d  = ST_COLLECT;
            rd_cnt_d = '0;
          end else begin
            rd_cnt_d = rd_cnt_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a generation end always opens a readout
  `TKFS_ASSERT(a_last_starts_readout, (in_accept && in_data_i.gen_last) |=> (state_q == ST_READOUT), "gen_last item did not start readout")

  // the final pop empties the whole chain and returns to collecting
  `TKFS_ASSERT(a_readout_clears, last_pop |=> ((cell_valid == '0) && (state_q == ST_COLLECT)), "readout end left places filled")

  // filled places always form an unbroken run from the best place down
  `TKFS_ASSERT_NEVER(a_valid_prefix, (((cell_valid + 1'b1) & cell_valid) != '0), "gap in filled places")

  // results leave only with a rank inside the places in use
  `TKFS_ASSERT(a_rank_in_range, out_valid_o |-> (CNT_W'(out_data_o.rank) < places_n), "result rank beyond places in use")

  // a place is only claimed by an item being taken
  `TKFS_ASSERT_NEVER(a_take_needs_accept, taken[TOP_PLACES] && !in_accept, "place claimed without item")

endmodule

@@ sim/tb_top_k_fitness_selector.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the top k fitness selector, with its own ranking predictor
module tb_top_k_fitness_selector;
  import tkfs_pkg::*;

  // clock, run length and idling
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 19;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 100;

  localparam logic [COUNT_W-1:0] COUNT_DEFAULT = COUNT_W'(TOP_PLACES);

  // notable fitness values, q16.16
  localparam logic signed [31:0] FIT_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] FIT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] FIT_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] FIT_ZERO = 32'sh0000_0000;

  // how random fitness values are drawn
  typedef enum int {
    FIT_ANY,
    FIT_NEAR_ZERO,
    FIT_EDGE
  } fit_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  tkfs_in_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  tkfs_out_t          out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i;

  top_k_fitness_selector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state: a private copy of the ranking list and the count
  logic [COUNT_W-1:0] count_reg;
  logic               place_used  [TOP_PLACES];
  logic [15:0]        place_ident [TOP_PLACES];
  logic signed [31:0] place_score [TOP_PLACES];

  // ranked places still owed by the block, oldest first
  tkfs_out_t expected_places [$];
  // candidates waiting for the input driver
  tkfs_in_t  pending_items [$];

  int  queued_total;
  int  taken_total;
  bit  in_taken;
  bit  in_idle_on;
  bit  out_idle_on;
  int  mismatch_count;
  int  cycle_count;

  // clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // number of places in use, with zero lifted to one and large counts saturated
  function automatic int places_kept();
    if (count_reg == '0) return 1;
    if (int'(count_reg) > TOP_PLACES) return TOP_PLACES;
    return int'(count_reg);
  endfunction

  // insert one accepted candidate and, on the last of a generation, queue the readout
  task automatic rank_candidate(tkfs_in_t item);
    int        n;
    int        p;
    int        i;
    bit        placed;
    tkfs_out_t res;
    n      = places_kept();
    placed = 1'b0;
    for (p = 0; p < n && !placed; p++) begin
      if (!place_used[p]) begin
        // first empty place takes it
        place_used[p]  = 1'b1;
        place_ident[p] = item.cand_id;
        place_score[p] = item.cand_fitness;
        placed         = 1'b1;
      end else if ($signed(item.cand_fitness) > place_score[p]) begin
        // strictly better: shift the filled places below down by one
        for (i = n - 1; i > p; i--) begin
          if (place_used[i-1]) begin
            place_used[i]  = 1'b1;
            place_ident[i] = place_ident[i-1];
            place_score[i] = place_score[i-1];
          end
        end
        place_ident[p] = item.cand_id;
        place_score[p] = item.cand_fitness;
        placed         = 1'b1;
      end
    end
    if (item.gen_last) begin
      for (i = 0; i < n; i++) begin
        res.rank         = RANK_W'(i);
        res.best_id      = place_used[i] ? place_ident[i] : 16'h0000;
        res.best_fitness = place_used[i] ? place_score[i] : FIT_ZERO;
        res.slot_filled  = place_used[i];
        res.last_place   = (i == n - 1);
        expected_places.push_back(res);
      end
      // readout clears every place, also those beyond the current count
      for (i = 0; i < TOP_PLACES; i++) place_used[i] = 1'b0;
    end
  endtask

  // one line per mismatch
  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic tkfs_in_t make_candidate(logic [15:0] id, logic signed [31:0] fit,
                                              logic last);
    tkfs_in_t item;
    item.cand_id      = id;
    item.cand_fitness = fit;
    item.gen_last     = last;
    return item;
  endfunction

  function automatic logic signed [31:0] random_fitness(fit_mode_e mode);
    case (mode)
      FIT_NEAR_ZERO: begin
        // narrow range so that ties are common
        return 32'($signed($urandom_range(4)) - 2);
      end
      FIT_EDGE: begin
        case ($urandom_range(6))
          0:       return FIT_MIN;
          1:       return FIT_MIN + 1;
          2:       return -1;
          3:       return FIT_ZERO;
          4:       return 1;
          5:       return FIT_MAX - 1;
          default: return FIT_MAX;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // hand one candidate to the input driver and wait until the block takes it
  task automatic send_candidate(tkfs_in_t item);
    pending_items.push_back(item);
    queued_total++;
    wait (taken_total == queued_total);
  endtask

  // let the block go quiet: nothing queued, nothing owed, then a few spare cycles
  task automatic wait_until_idle();
    while (pending_items.size() != 0 || taken_total != queued_total ||
           expected_places.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write active_count while the block is idle
  task automatic write_active_count(logic [COUNT_W-1:0] value);
    wait_until_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // input driver: a new candidate only once the previous one has gone,
  // with random gaps while idling is on
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (rst_ni && pending_items.size() != 0 &&
          !(in_idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stalls at random, every phase of the readout included
  always @(negedge clk_i) begin
    out_stall_i <= out_idle_on && ($urandom_range(99) < IDLE_PERCENT);
  end

  // input monitor: every taken candidate goes through the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rank_candidate(in_data_i);
      in_taken = 1'b1;
      taken_total++;
    end
  end

  // result checker: each taken result against the oldest expected place
  always @(posedge clk_i) begin : check_results
    tkfs_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_places.size() == 0) begin
        report_mismatch($sformatf("unexpected result rank %0d id %h",
                                  out_data_o.rank, out_data_o.best_id));
      end else begin
        want = expected_places.pop_front();
        if (out_data_o.rank !== want.rank)
          report_mismatch($sformatf("rank got %0d exp %0d", out_data_o.rank, want.rank));
        if (out_data_o.best_id !== want.best_id)
          report_mismatch($sformatf("rank %0d best_id got %h exp %h",
                                    want.rank, out_data_o.best_id, want.best_id));
        if (out_data_o.best_fitness !== want.best_fitness)
          report_mismatch($sformatf("rank %0d best_fitness got %h exp %h",
                                    want.rank, out_data_o.best_fitness, want.best_fitness));
        if (out_data_o.slot_filled !== want.slot_filled)
          report_mismatch($sformatf("rank %0d slot_filled got %b exp %b",
                                    want.rank, out_data_o.slot_filled, want.slot_filled));
        if (out_data_o.last_place !== want.last_place)
          report_mismatch($sformatf("rank %0d last_place got %b exp %b",
                                    want.rank, out_data_o.last_place, want.last_place));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // default count of eight, short generation: most places come back empty
  task automatic test_default_count();
    send_candidate(make_candidate(16'h0101, FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h0202, -FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h0303, FIT_ONE + 1, 1'b1));
  endtask

  // extremes of id and fitness, more candidates than places so the bottom drops out
  task automatic test_field_extremes();
    write_active_count(COUNT_DEFAULT);
    send_candidate(make_candidate(16'h0000, FIT_ZERO, 1'b0));
    send_candidate(make_candidate(16'hffff, FIT_MAX, 1'b0));
    send_candidate(make_candidate(16'h1234, FIT_MIN, 1'b0));
    send_candidate(make_candidate(16'haaaa, -1, 1'b0));
    send_candidate(make_candidate(16'h5555, 1, 1'b0));
    send_candidate(make_candidate(16'h8000, FIT_MAX, 1'b0));
    send_candidate(make_candidate(16'h7fff, FIT_MIN + 1, 1'b0));
    send_candidate(make_candidate(16'h0001, FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'hfffe, -FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h00ff, FIT_MIN, 1'b1));
  endtask

  // equal fitness: the earlier arrival stays ahead
  task automatic test_ties();
    write_active_count(COUNT_W'(3));
    send_candidate(make_candidate(16'h0011, FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h0022, FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h0033, FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'h0044, FIT_ONE, 1'b1));
  endtask

  // single place, a count of zero acting as one, a count that saturates
  task automatic test_count_extremes();
    write_active_count(COUNT_W'(1));
    send_candidate(make_candidate(16'hc001, -FIT_ONE, 1'b0));
    send_candidate(make_candidate(16'hc002, FIT_ONE, 1'b1));
    write_active_count('0);
    send_candidate(make_candidate(16'hc003, FIT_MIN, 1'b1));
    write_active_count('1);
    send_candidate(make_candidate(16'hc004, FIT_MAX, 1'b1));
  endtask

  // count lowered in the middle of a generation, then a full list shows the clearing
  task automatic test_count_change_mid_generation();
    write_active_count(COUNT_DEFAULT);
    send_candidate(make_candidate(16'hd010, 32'sd10, 1'b0));
    send_candidate(make_candidate(16'hd020, 32'sd20, 1'b0));
    send_candidate(make_candidate(16'hd030, 32'sd30, 1'b0));
    write_active_count(COUNT_W'(2));
    send_candidate(make_candidate(16'hd025, 32'sd25, 1'b1));
    write_active_count(COUNT_DEFAULT);
    send_candidate(make_candidate(16'hd001, 32'sd1, 1'b1));
  endtask

  // random generations with random counts, a stretch in the middle without idling
  task automatic test_random_generations();
    int        sent;
    int        gen_len;
    int        k;
    fit_mode_e mode;
    tkfs_in_t  item;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_idle_on  = !(sent >= 50 && sent < 90);
      out_idle_on = in_idle_on;
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(7) == 0) write_active_count(COUNT_W'($urandom_range(15)));
        else write_active_count(COUNT_W'($urandom_range(1, TOP_PLACES)));
      end
      // mostly ordinary generations, now and then a long one
      gen_len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      mode    = fit_mode_e'($urandom_range(2));
      for (k = 0; k < gen_len; k++) begin
        if (k == gen_len / 2 && k != 0 && $urandom_range(7) == 0)
          write_active_count(COUNT_W'($urandom_range(1, TOP_PLACES)));
        item.cand_id      = 16'($urandom);
        item.cand_fitness = random_fitness(mode);
        item.gen_last     = (k == gen_len - 1);
        send_candidate(item);
        sent++;
      end
    end
  endtask

  initial begin
    integer i;
    // known values on every input from time zero
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_taken       = 1'b0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    queued_total   = 0;
    taken_total    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    // predictor after reset
    count_reg = COUNT_DEFAULT;
    for (i = 0; i < TOP_PLACES; i++) begin
      place_used[i]  = 1'b0;
      place_ident[i] = '0;
      place_score[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_count();
    test_field_extremes();
    test_ties();
    test_count_extremes();
    test_count_change_mid_generation();
    test_random_generations();

    // drain: everything owed must arrive, then a short quiet spell
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_places.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tkfs_pkg.sv
design/tkfs_cell.sv
design/top_k_fitness_selector.sv
sim/tb_top_k_fitness_selector.sv
